@@ sv/pointer_deadband_and_screen_scaler_unit_assert.svh @@
// assertion macros for the pointer deadband and screen scaler unit
`ifndef POINTER_DEADBAND_AND_SCREEN_SCALER_UNIT_ASSERT_SVH
`define POINTER_DEADBAND_AND_SCREEN_SCALER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PDSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdss assertion failed");

// next-cycle implication, checked outside reset
`define PDSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdss assertion failed");

`endif

@@ sv/pdss_pkg.sv @@
// ----------------------------------------------------------------------------
// pdss_pkg
// shared types and constants of the pointer deadband and screen scaler
// ----------------------------------------------------------------------------
package pdss_pkg;

  localparam int CoordBits    = 10;
  localparam int ScreenBits   = 12;
  localparam int DeadbandBits = 4;
  localparam int RegAddrBits  = 5;
  localparam int RegIdxBits   = 3;
  localparam int DataBits     = 32;

  localparam logic [CoordBits-1:0]    LeftEdgeReset    = CoordBits'(0);
  localparam logic [CoordBits-1:0]    RightEdgeReset   = CoordBits'(639);
  localparam logic [CoordBits-1:0]    TopEdgeReset     = CoordBits'(0);
  localparam logic [CoordBits-1:0]    BottomEdgeReset  = CoordBits'(479);
  localparam logic [ScreenBits-1:0]   ScreenWidthReset = ScreenBits'(1920);
  localparam logic [ScreenBits-1:0]   ScreenHeightReset = ScreenBits'(1080);
  localparam logic [DeadbandBits-1:0] DeadbandReset    = DeadbandBits'(3);

  // register indexes, byte address is 4 * index
  localparam logic [RegIdxBits-1:0] RegLeftEdge    = 3'd0;
  localparam logic [RegIdxBits-1:0] RegRightEdge   = 3'd1;
  localparam logic [RegIdxBits-1:0] RegTopEdge     = 3'd2;
  localparam logic [RegIdxBits-1:0] RegBottomEdge  = 3'd3;
  localparam logic [RegIdxBits-1:0] RegScreenWidth = 3'd4;
  localparam logic [RegIdxBits-1:0] RegScreenHeight = 3'd5;
  localparam logic [RegIdxBits-1:0] RegDeadband    = 3'd6;

  typedef struct packed {
    logic [CoordBits-1:0]    left_edge;
    logic [CoordBits-1:0]    right_edge;
    logic [CoordBits-1:0]    top_edge;
    logic [CoordBits-1:0]    bottom_edge;
    logic [ScreenBits-1:0]   screen_width;
    logic [ScreenBits-1:0]   screen_height;
    logic [DeadbandBits-1:0] deadband;
  } cfg_t;

  typedef struct packed {
    logic [CoordBits-1:0] tip_x;
    logic [CoordBits-1:0] tip_y;
  } in_req_t;

  typedef struct packed {
    logic [ScreenBits-1:0] cursor_x;
    logic [ScreenBits-1:0] cursor_y;
    logic                  calib_error;
  } out_req_t;

endpackage

@@ sv/pdss_regs.sv @@
// ----------------------------------------------------------------------------
// pdss_regs
// apb register file holding calibration window, screen size and deadband
// ----------------------------------------------------------------------------
module pdss_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [pdss_pkg::RegAddrBits-1:0]      paddr,
  input  logic [pdss_pkg::DataBits-1:0]         pwdata,
  output logic [pdss_pkg::DataBits-1:0]         prdata,
  output logic                                  pready,
  output pdss_pkg::cfg_t                        cfg_o
);
  import pdss_pkg::*;

  cfg_t                  cfg_q;
  logic                  wr_en;
  logic [RegIdxBits-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[RegAddrBits-1:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_edge     <= LeftEdgeReset;
      cfg_q.right_edge    <= RightEdgeReset;
      cfg_q.top_edge      <= TopEdgeReset;
      cfg_q.bottom_edge   <= BottomEdgeReset;
      cfg_q.screen_width  <= ScreenWidthReset;
      cfg_q.screen_height <= ScreenHeightReset;
      cfg_q.deadband      <= DeadbandReset;
    end else if (wr_en) begin
      case (idx)
        RegLeftEdge:     cfg_q.left_edge     <= pwdata[CoordBits-1:0];
        RegRightEdge:    cfg_q.right_edge    <= pwdata[CoordBits-1:0];
        RegTopEdge:      cfg_q.top_edge      <= pwdata[CoordBits-1:0];
        RegBottomEdge:   cfg_q.bottom_edge   <= pwdata[CoordBits-1:0];
        RegScreenWidth:  cfg_q.screen_width  <= pwdata[ScreenBits-1:0];
        RegScreenHeight: cfg_q.screen_height <= pwdata[ScreenBits-1:0];
        RegDeadband:     cfg_q.deadband      <= pwdata[DeadbandBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegLeftEdge:     prdata = DataBits'(cfg_q.left_edge);
      RegRightEdge:    prdata = DataBits'(cfg_q.right_edge);
      RegTopEdge:      prdata = DataBits'(cfg_q.top_edge);
      RegBottomEdge:   prdata = DataBits'(cfg_q.bottom_edge);
      RegScreenWidth:  prdata = DataBits'(cfg_q.screen_width);
      RegScreenHeight: prdata = DataBits'(cfg_q.screen_height);
      RegDeadband:     prdata = DataBits'(cfg_q.deadband);
      default:         prdata = '0;
    endcase
  end

endmodule

@@ sv/pdss_div.sv @@
// ----------------------------------------------------------------------------
// pdss_div
// shared radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pdss_div #(
  parameter int DividendBits = 22,
  parameter int DivisorBits  = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [DividendBits-1:0] dividend_i,
  input  logic [DivisorBits-1:0]  divisor_i,
  output logic [DividendBits-1:0] quotient_o,
  output logic                    done_o
);
  import pdss_pkg::*;

  localparam int CntBits = $clog2(DividendBits + 1);

  logic [DivisorBits-1:0]  rem_q;
  logic [DividendBits-1:0] quo_q;
  logic [CntBits-1:0]      cnt_q;
  logic                    busy_q;
  logic                    done_q;

  logic [DivisorBits:0]    shifted;
  logic [DivisorBits-1:0]  trial;
  logic                    fits;

  // shift in next dividend bit and try the subtract
  assign shifted = {rem_q, quo_q[DividendBits-1]};
  assign trial   = shifted[DivisorBits-1:0] - divisor_i;
  assign fits    = shifted >= {1'b0, divisor_i};

  assign quotient_o = quo_q;
  assign done_o     = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntBits'(DividendBits);
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == CntBits'(1));
      if (busy_q) begin
        cnt_q <= cnt_q - CntBits'(1);
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial : shifted[DivisorBits-1:0];
      quo_q <= {quo_q[DividendBits-2:0], fits};
    end
  end

endmodule

@@ sv/pointer_deadband_and_screen_scaler_unit.sv @@
// ----------------------------------------------------------------------------
// pointer_deadband_and_screen_scaler_unit
// per-axis deadband filter on a fingertip position, then linear mapping of
// the held coordinate from the calibration window onto the screen
// ----------------------------------------------------------------------------
// a request is taken only in idle; each axis then runs StMul, StDivStart
// and StDivWait, and StOut waits while the old result is stalled; an axis
//   with a zero-size window skips its divide
// the shared 22-step divider runs once per axis with a nonzero window
// reset: held coordinates and the previous-sample flag clear, registers take
//   their defaults, no result is pending
module pointer_deadband_and_screen_scaler_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input request channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  pdss_pkg::in_req_t                  in_data_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output pdss_pkg::out_req_t                 out_data_o,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pdss_pkg::RegAddrBits-1:0]   paddr,
  input  logic [pdss_pkg::DataBits-1:0]      pwdata,
  output logic [pdss_pkg::DataBits-1:0]      prdata,
  output logic                               pready
);
  import pdss_pkg::*;

  // |held - edge1| * screen fits in coord + screen bits
  localparam int ProdBits = CoordBits + ScreenBits;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StDivStart,
    StDivWait,
    StOut
  } state_e;

  state_e                 state_q;
  logic                   axis_q;       // 0: x axis, 1: y axis
  logic                   have_prev_q;
  logic                   out_valid_q;

  logic [CoordBits-1:0]   held_x_q;
  logic [CoordBits-1:0]   held_y_q;
  logic [ProdBits-1:0]    dividend_q;
  logic [CoordBits-1:0]   divisor_q;
  logic                   neg_q;        // quotient sign is negative
  logic                   err_q;
  logic [ScreenBits-1:0]  cur_x_q;
  logic [ScreenBits-1:0]  cur_y_q;
  out_req_t               out_q;

  cfg_t                   cfg;
  logic                   in_accept;
  logic                   out_free;
  logic [CoordBits-1:0]   held_x_d;
  logic [CoordBits-1:0]   held_y_d;

  // operand selection for the axis in work
  logic [CoordBits-1:0]   pos;
  logic [CoordBits-1:0]   edge1;
  logic [CoordBits-1:0]   edge2;
  logic [ScreenBits-1:0]  scr;
  logic [CoordBits:0]     span;
  logic [CoordBits:0]     dpos;
  logic [CoordBits-1:0]   span_abs;
  logic [CoordBits-1:0]   dpos_abs;
  logic [ProdBits-1:0]    prod;
  logic                   span_zero;

  logic                   div_start;
  logic                   div_done;
  logic [ProdBits-1:0]    div_quo;
  logic [ScreenBits-1:0]  axis_res;

  pdss_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // keep the held value unless the move reaches the deadband
  function automatic logic [CoordBits-1:0] filter_axis(
    input logic [CoordBits-1:0]    held,
    input logic [CoordBits-1:0]    fresh,
    input logic                    have_prev,
    input logic [DeadbandBits-1:0] db
  );
    logic [CoordBits-1:0] diff;
    diff = (fresh > held) ? (fresh - held) : (held - fresh);
    if (have_prev && (diff < CoordBits'(db))) begin
      return held;
    end
    return fresh;
  endfunction

  assign in_stall_o = (state_q != StIdle);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign held_x_d = filter_axis(held_x_q, in_data_i.tip_x, have_prev_q, cfg.deadband);
  assign held_y_d = filter_axis(held_y_q, in_data_i.tip_y, have_prev_q, cfg.deadband);

  always_comb begin
    pos   = axis_q ? held_y_q : held_x_q;
    edge1 = axis_q ? cfg.top_edge : cfg.left_edge;
    edge2 = axis_q ? cfg.bottom_edge : cfg.right_edge;
    scr   = axis_q ? cfg.screen_height : cfg.screen_width;
  end

  // signed differences one bit wider than a coordinate, then magnitudes
  assign span      = {1'b0, edge2} - {1'b0, edge1};
  assign dpos      = {1'b0, pos} - {1'b0, edge1};
  assign span_abs  = span[CoordBits] ? CoordBits'(-span) : span[CoordBits-1:0];
  assign dpos_abs  = dpos[CoordBits] ? CoordBits'(-dpos) : dpos[CoordBits-1:0];
  assign span_zero = (span == '0);
  assign prod      = ProdBits'(dpos_abs) * ProdBits'(scr);

  assign div_start = (state_q == StDivStart);

  pdss_div #(
    .DividendBits (ProdBits),
    .DivisorBits  (CoordBits)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend_q),
    .divisor_i  (divisor_q),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  // a negative quotient clamps to zero, a large one to the screen size
  always_comb begin
    if (neg_q) begin
      axis_res = '0;
    end else if (div_quo > ProdBits'(scr)) begin
      axis_res = scr;
    end else begin
      axis_res = div_quo[ScreenBits-1:0];
    end
  end

  // sequencer: filter on accept, then multiply and, for a nonzero window, divide per axis
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      axis_q      <= 1'b0;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
      held_x_q    <= '0;
      held_y_q    <= '0;
    end else begin
      // a new result replaces the one taken in the same cycle
      if ((state_q == StOut) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_accept) begin
            held_x_q    <= held_x_d;
            held_y_q    <= held_y_d;
            have_prev_q <= 1'b1;
            axis_q      <= 1'b0;
            state_q     <= StMul;
          end
        end
        StMul: begin
          if (span_zero) begin
            // zero-size window: axis result is zero, skip the divide
            axis_q  <= 1'b1;
            state_q <= axis_q ? StOut : StMul;
          end else begin
            state_q <= StDivStart;
          end
        end
        StDivStart: begin
          state_q <= StDivWait;
        end
        StDivWait: begin
          if (div_done) begin
            axis_q  <= 1'b1;
            state_q <= axis_q ? StOut : StMul;
          end
        end
        StOut: begin
          // result register frees up when the old result is taken
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      err_q <= 1'b0;
    end
    if (state_q == StMul) begin
      dividend_q <= prod;
      divisor_q  <= span_abs;
      neg_q      <= span[CoordBits] ^ dpos[CoordBits];
      if (span_zero) begin
        err_q <= 1'b1;
        if (axis_q) begin
          cur_y_q <= '0;
        end else begin
          cur_x_q <= '0;
        end
      end
    end
    if ((state_q == StDivWait) && div_done) begin
      if (axis_q) begin
        cur_y_q <= axis_res;
      end else begin
        cur_x_q <= axis_res;
      end
    end
    if ((state_q == StOut) && out_free) begin
      out_q.cursor_x    <= cur_x_q;
      out_q.cursor_y    <= cur_y_q;
      out_q.calib_error <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ sv/pdss_checker.sv @@
// ----------------------------------------------------------------------------
// pdss_checker
// port-level checks on the pointer deadband and screen scaler unit
// ----------------------------------------------------------------------------
`include "pointer_deadband_and_screen_scaler_unit_assert.svh"

module pdss_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input pdss_pkg::out_req_t out_data_o
);
  import pdss_pkg::*;

  logic in_acc;
  logic out_held;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_held = out_valid_o && out_stall_i;

  // an accepted request keeps the block busy
  `PDSS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, in_stall_o)

  // leaving busy always hands over a result
  `PDSS_ASSERT_NOW(a_done_gives_result, clk_i, rst_ni, $fell(in_stall_o), out_valid_o)

  // a fresh result appears only as the block returns to idle
  `PDSS_ASSERT_NOW(a_result_at_idle, clk_i, rst_ni, $rose(out_valid_o), !in_stall_o)

  // a stalled result holds
  `PDSS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_data_o))

endmodule

bind pointer_deadband_and_screen_scaler_unit pdss_checker u_pdss_checker (.*);
